/* rtl/vpd_pkg.sv */
// Package: payload types, configuration view, state codes and reset values.
`default_nettype none
package vpd_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] baseline;
  } vpd_in_t;

  typedef struct packed {
    logic       vehicle_counted;
    logic [1:0] detector_state;
  } vpd_out_t;

  // Live register values seen by the detector
  typedef struct packed {
    logic [15:0] upper_threshold;
    logic [15:0] lower_threshold;
    logic [7:0]  confirm_count;
    logic [15:0] max_amplitude;
  } vpd_cfg_t;

  localparam int unsigned DEV_W   = 17;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned RIDX_W  = 3;

  localparam logic [1:0] ST_WAITING  = 2'd0;
  localparam logic [1:0] ST_DETECTED = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  localparam logic [RIDX_W-1:0] REG_UPPER   = 3'd0;
  localparam logic [RIDX_W-1:0] REG_LOWER   = 3'd1;
  localparam logic [RIDX_W-1:0] REG_CONFIRM = 3'd2;
  localparam logic [RIDX_W-1:0] REG_HOLDOFF = 3'd3;
  localparam logic [RIDX_W-1:0] REG_MAXAMP  = 3'd4;

  localparam logic [15:0] UPPER_RST   = 16'd20;
  localparam logic [15:0] LOWER_RST   = 16'd10;
  localparam logic [7:0]  CONFIRM_RST = 8'd1;
  localparam logic [15:0] HOLDOFF_RST = 16'd0;
  localparam logic [15:0] MAXAMP_RST  = 16'd250;

  localparam logic [7:0]  RUN_MAX     = 8'd255;

  // Two's complement magnitude; the most negative code gives 32768
  function automatic logic [DEV_W-1:0] mag16(input logic [15:0] v);
    logic [DEV_W-1:0] ext;
    ext = {1'b0, v};
    if (v[15]) begin
      return 17'h10000 - ext;
    end
    return ext;
  endfunction

endpackage
`default_nettype wire

/* rtl/vehicle_presence_detector_core.sv */
// Top level: vehicle presence detector with hysteresis and confirm-count debounce.
`default_nettype none
// One result per accepted request: it passes from the input register to the result
// register, which takes it when the result is not stalled. A new request can be taken
// every cycle while the result is not stalled: detector state, run count and holdoff
// count update together in the result stage, which sets the one-request-per-cycle rate.
// A stalled result holds the request in the input register and so stalls the input. The
// holdoff count loads only at reset, when it is back at zero, so a write to it is stored and read back
// but does not change detection. Write configuration only while no request is in flight.
module vehicle_presence_detector_core
  import vpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vpd_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vpd_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  vpd_cfg_t         cfg;
  logic             take;
  logic             dev_valid;
  logic [DEV_W-1:0] dev;

  vpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vpd_dev u_dev (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .take      (take),
    .dev_valid (dev_valid),
    .dev       (dev)
  );

  vpd_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .dev_valid (dev_valid),
    .dev       (dev),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/vpd_cfg.sv */
// APB-style register file for thresholds, confirm count, holdoff and amplitude limit.
`default_nettype none
module vpd_cfg
  import vpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output vpd_cfg_t               cfg
);

  logic [15:0] upper_r;
  logic [15:0] lower_r;
  logic [7:0]  confirm_r;
  logic [15:0] holdoff_r;
  logic [15:0] maxamp_r;
  logic [RIDX_W-1:0] idx;
  logic        wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r   <= UPPER_RST;
      lower_r   <= LOWER_RST;
      confirm_r <= CONFIRM_RST;
      holdoff_r <= HOLDOFF_RST;
      maxamp_r  <= MAXAMP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_UPPER:   upper_r   <= pwdata[15:0];
        REG_LOWER:   lower_r   <= pwdata[15:0];
        REG_CONFIRM: confirm_r <= pwdata[7:0];
        REG_HOLDOFF: holdoff_r <= pwdata[15:0];
        REG_MAXAMP:  maxamp_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_UPPER:   prdata = {16'd0, upper_r};
      REG_LOWER:   prdata = {16'd0, lower_r};
      REG_CONFIRM: prdata = {24'd0, confirm_r};
      REG_HOLDOFF: prdata = {16'd0, holdoff_r};
      REG_MAXAMP:  prdata = {16'd0, maxamp_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.upper_threshold = upper_r;
  assign cfg.lower_threshold = lower_r;
  assign cfg.confirm_count   = confirm_r;
  assign cfg.max_amplitude   = maxamp_r;

endmodule
`default_nettype wire

/* rtl/vpd_dev.sv */
// Input register stage and deviation | |sample| - |baseline| |.
`default_nettype none
module vpd_dev
  import vpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire vpd_in_t    in_data,
  input  wire logic       take,
  output logic            dev_valid,
  output logic [DEV_W-1:0] dev
);

  vpd_in_t          in_r;
  logic             v_r;
  logic             v_nxt;
  logic             ready;
  logic [DEV_W-1:0] ms;
  logic [DEV_W-1:0] mb;

  // Free when empty or when the held request moves on this cycle
  assign ready    = !v_r || take;
  assign in_stall = !ready;
  assign v_nxt    = ready ? in_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready) begin
      in_r <= in_data;
    end
  end

  assign ms        = mag16(in_r.sample);
  assign mb        = mag16(in_r.baseline);
  assign dev       = (ms >= mb) ? (ms - mb) : (mb - ms);
  assign dev_valid = v_r;

endmodule
`default_nettype wire

/* rtl/vpd_fsm.sv */
// Detector state, run and holdoff counters, and the result register.
`default_nettype none
module vpd_fsm
  import vpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vpd_cfg_t         cfg,
  input  wire logic             dev_valid,
  input  wire logic [DEV_W-1:0] dev,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output vpd_out_t              out_data
);

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  run_r, run_nxt, run_inc;
  logic [15:0] holdoff_r, holdoff_nxt;
  logic        counted;
  logic        out_valid_r;
  vpd_out_t    out_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = dev_valid && out_free;
  assign run_inc  = (run_r == RUN_MAX) ? RUN_MAX : run_r + 8'd1;

  always_comb begin
    state_nxt   = state_r;
    run_nxt     = run_r;
    holdoff_nxt = holdoff_r;
    counted     = 1'b0;
    priority if (dev > {1'b0, cfg.max_amplitude}) begin
      // Amplitude error: counters hold
      state_nxt = ST_ERROR;
    end else if (holdoff_r != 16'd0) begin
      holdoff_nxt = holdoff_r - 16'd1;
      run_nxt     = 8'd0;
    end else if (state_r == ST_WAITING) begin
      if (dev > {1'b0, cfg.upper_threshold}) begin
        run_nxt = run_inc;
        if (run_inc >= cfg.confirm_count) begin
          counted   = 1'b1;
          state_nxt = ST_DETECTED;
        end
      end else begin
        run_nxt = 8'd0;
      end
    end else begin
      if (dev < {1'b0, cfg.lower_threshold}) begin
        run_nxt = run_inc;
        if (run_inc >= cfg.confirm_count) begin
          state_nxt = ST_WAITING;
        end
      end else begin
        run_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAITING;
      run_r       <= 8'd0;
      holdoff_r   <= HOLDOFF_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r   <= state_nxt;
        run_r     <= run_nxt;
        holdoff_r <= holdoff_nxt;
      end
      if (out_free) begin
        out_valid_r <= dev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r.vehicle_counted <= counted;
      out_r.detector_state  <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_in_detected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.vehicle_counted |-> out_r.detector_state == ST_DETECTED)
    else $error("vehicle counted without entering detected state");

  a_count_from_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    take && counted |-> state_r == ST_WAITING)
    else $error("vehicle counted outside waiting state");

  a_holdoff_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> holdoff_r <= $past(holdoff_r))
    else $error("holdoff counter increased");

  a_state_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(state_r) && $stable(run_r))
    else $error("detector state moved without a request");

endmodule
`default_nettype wire

/* test/vehicle_presence_detector_checker.sv */
// Checker: predicts detector results from the observed requests and compares them.
module vehicle_presence_detector_checker
  import vpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire vpd_in_t           in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire vpd_out_t          out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output int                     mismatches,
  output int                     outstanding
);

  logic [15:0] upper_thr;
  logic [15:0] lower_thr;
  logic [7:0]  confirm_need;
  logic [15:0] max_amp;

  logic [1:0]  det_state;
  logic [7:0]  run_len;
  logic [15:0] holdoff_left;

  vpd_out_t predicted_results[$];
  int       mismatch_count = 0;
  int       pending_count = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = pending_count;

  function automatic int axis_magnitude(logic signed [15:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic vpd_out_t predict_detector(vpd_in_t req);
    int       dev;
    vpd_out_t res;
    dev = axis_magnitude(req.sample) - axis_magnitude(req.baseline);
    if (dev < 0) begin
      dev = -dev;
    end
    res.vehicle_counted = 1'b0;
    if (dev > int'(max_amp)) begin
      // over range: force error, leave the counters alone
      det_state = ST_ERROR;
    end else if (holdoff_left != 16'd0) begin
      holdoff_left = holdoff_left - 16'd1;
      run_len      = '0;
    end else if (det_state == ST_WAITING) begin
      if (dev > int'(upper_thr)) begin
        if (run_len != RUN_MAX) begin
          run_len = run_len + 8'd1;
        end
        if (run_len >= confirm_need) begin
          res.vehicle_counted = 1'b1;
          det_state           = ST_DETECTED;
        end
      end else begin
        run_len = '0;
      end
    end else begin
      if (dev < int'(lower_thr)) begin
        if (run_len != RUN_MAX) begin
          run_len = run_len + 8'd1;
        end
        if (run_len >= confirm_need) begin
          det_state = ST_WAITING;
        end
      end else begin
        run_len = '0;
      end
    end
    res.detector_state = det_state;
    return res;
  endfunction

  always @(posedge clk) begin
    vpd_out_t want;
    if (!rst_n) begin
      upper_thr    = UPPER_RST;
      lower_thr    = LOWER_RST;
      confirm_need = CONFIRM_RST;
      max_amp      = MAXAMP_RST;
      det_state    = ST_WAITING;
      run_len      = '0;
      // holdoff loads only here, so later register writes never reach it
      holdoff_left = HOLDOFF_RST;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_UPPER:   upper_thr    = pwdata[15:0];
          REG_LOWER:   lower_thr    = pwdata[15:0];
          REG_CONFIRM: confirm_need = pwdata[7:0];
          REG_MAXAMP:  max_amp      = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result with no request pending: counted=%0d state=%0d",
                     $time, out_data.vehicle_counted, out_data.detector_state);
          end
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.vehicle_counted !== want.vehicle_counted ||
              out_data.detector_state !== want.detector_state) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch: counted exp %0d got %0d, state exp %0d got %0d",
                       $time, want.vehicle_counted, out_data.vehicle_counted,
                       want.detector_state, out_data.detector_state);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(predict_detector(in_data));
      end
    end
    pending_count = predicted_results.size();
  end

endmodule

/* test/vehicle_presence_detector_core_test.sv */
// Testbench top: drives requests and register writes, and reports the verdict.
module vehicle_presence_detector_core_test;
  import vpd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DEV_FULL    = 32768;
  localparam logic [RIDX_W-1:0] REG_SPARE = 3'd5;

  typedef enum logic [1:0] {BAND_LOW, BAND_MID, BAND_HIGH, BAND_OVER} dev_band_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  vpd_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vpd_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic req_taken = 1'b0;
  logic write_taken = 1'b0;

  // register values as last written, used to shape the deviations
  int upper_set = 20;
  int lower_set = 10;
  int confirm_set = 1;
  int maxamp_set = 250;
  dev_band_t band = BAND_LOW;

  vehicle_presence_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  vehicle_presence_detector_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    req_taken   <= in_valid && !in_stall;
    write_taken <= psel && penable && pwrite && pready;
    cycles      <= cycles + 1;
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Every task starts and ends just after a falling edge
  task automatic send_reading(input logic [15:0] s, input logic [15:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{sample: s, baseline: b};
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!write_taken);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input int up, input int lo, input int cnt, input int hold,
                           input int amp);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    write_reg(REG_CONFIRM, cnt);
    write_reg(REG_HOLDOFF, hold);
    write_reg(REG_MAXAMP, amp);
    upper_set   = up;
    lower_set   = lo;
    confirm_set = cnt;
    maxamp_set  = amp;
  endtask

  // Drop valid, wait for every result, then let the pipeline drain
  task automatic settle();
    in_valid = 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_dev(input int lo, input int hi);
    int sel;
    if (hi > DEV_FULL) begin
      hi = DEV_FULL;
    end
    if (lo < 0) begin
      lo = 0;
    end
    if (lo > hi) begin
      return $urandom_range(DEV_FULL);
    end
    sel = $urandom_range(9);
    if (sel == 0) begin
      return lo;
    end
    if (sel == 1) begin
      return hi;
    end
    return lo + $urandom_range(hi - lo);
  endfunction

  function automatic int band_deviation(input dev_band_t b);
    case (b)
      BAND_LOW:  return pick_dev(0, (lower_set - 1 < maxamp_set) ? lower_set - 1 : maxamp_set);
      BAND_MID:  return pick_dev(lower_set, (upper_set < maxamp_set) ? upper_set : maxamp_set);
      BAND_HIGH: return pick_dev(upper_set + 1, maxamp_set);
      default:   return pick_dev(maxamp_set + 1, DEV_FULL);
    endcase
  endfunction

  function automatic logic [15:0] signed_reading(input int mag);
    logic [15:0] r;
    r = mag[15:0];
    if (mag == DEV_FULL || $urandom_range(1) == 1) begin
      r = -r;
    end
    return r;
  endfunction

  task automatic send_deviation(input int dev);
    int lo_mag;
    int span;
    span   = DEV_FULL - dev;
    lo_mag = ($urandom_range(3) != 0 && span > 2000) ? $urandom_range(2000)
                                                      : $urandom_range(span);
    if ($urandom_range(1) == 1) begin
      send_reading(signed_reading(lo_mag + dev), signed_reading(lo_mag));
    end else begin
      send_reading(signed_reading(lo_mag), signed_reading(lo_mag + dev));
    end
  endtask

  task automatic send_random_reading();
    logic [31:0] raw;
    int          pick;
    raw = $urandom;
    // hold a deviation band for a few requests so runs build up
    if ($urandom_range(99) < 25) begin
      pick = $urandom_range(99);
      band = (pick < 40) ? BAND_LOW : (pick < 80) ? BAND_HIGH :
             (pick < 92) ? BAND_MID : BAND_OVER;
    end
    if ($urandom_range(99) < 8) begin
      send_reading(raw[31:16], raw[15:0]);
    end else begin
      send_deviation(band_deviation(band));
    end
  endtask

  task automatic run_phase(input int count, input int sender_pct, input int receiver_pct);
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
    repeat (count) send_random_reading();
    settle();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: upper 20, lower 10, confirm 1, limit 250
    send_reading(16'h0000, 16'h0000);
    send_reading(16'h0015, 16'h0000);
    send_reading(16'hFFFB, 16'h0000);
    send_reading(16'h0014, 16'h0000);
    send_reading(16'h8000, 16'h0000);
    send_reading(16'h0000, 16'h8000);
    send_reading(16'h7FFF, 16'h8000);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'h7FFF, 16'h7FFF);
    send_reading(16'h8001, 16'h7FFF);
    send_reading(16'h00FA, 16'h0000);
    send_reading(16'h00FB, 16'h0000);
    send_reading(16'h000A, 16'h0000);
    send_reading(16'h0009, 16'h0000);
    send_reading(16'h5555, 16'hAAAA);
    send_reading(16'hAAAA, 16'h5555);
    settle();

    // zero confirm count: first qualifying request changes state
    write_reg(REG_CONFIRM, 32'd0);
    confirm_set = 0;
    send_reading(16'h0064, 16'h0000);
    send_reading(16'h0003, 16'h0000);
    send_reading(16'h0000, 16'h0000);
    settle();

    // write beyond the register map must be ignored
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_reading(16'h0015, 16'h0000);
    send_reading(16'hFFF7, 16'h0000);
    settle();

    configure(20, 10, 1, 0, 250);
    run_phase(180, 0, 0);

    configure(300, 100, 3, 65535, 5000);
    run_phase(180, 72, 0);

    configure(0, 65535, 0, 0, 65535);
    run_phase(180, 0, 72);

    configure(65535, 0, 255, 4660, 0);
    run_phase(60, 16, 16);

    // long runs push the run counter into saturation
    configure(50, 40, 255, 0, 1000);
    idle_pct  = 16;
    stall_pct = 16;
    repeat (260) send_deviation(band_deviation(BAND_LOW));
    repeat (260) send_deviation(band_deviation(BAND_HIGH));
    repeat (5) send_deviation(band_deviation(BAND_LOW));
    repeat (5) send_deviation(band_deviation(BAND_HIGH));
    run_phase(50, 16, 16);

    configure(1000, 1200, 2, 0, 32767);
    run_phase(150, 16, 16);

    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/vpd_pkg.sv
rtl/vpd_cfg.sv
rtl/vpd_dev.sv
rtl/vpd_fsm.sv
rtl/vehicle_presence_detector_core.sv
test/vehicle_presence_detector_checker.sv
test/vehicle_presence_detector_core_test.sv
